FILE: hdl/ttt_pkg.sv
`default_nettype none
package ttt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int OP_W   = 2;
  localparam int EV_W   = 3;
  localparam int ID_W   = 32;
  localparam int DLY_W  = 32;
  localparam int TICK_W = 64;

  localparam logic [OP_W-1:0] OP_SET     = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd2;
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  localparam logic [EV_W-1:0] EV_SET_OK    = 3'd0;
  localparam logic [EV_W-1:0] EV_FULL      = 3'd1;
  localparam logic [EV_W-1:0] EV_CANCELLED = 3'd2;
  localparam logic [EV_W-1:0] EV_NOT_FOUND = 3'd3;
  localparam logic [EV_W-1:0] EV_EXPIRED   = 3'd4;
  localparam logic [EV_W-1:0] EV_TICK_DONE = 3'd5;

  typedef struct packed {
    logic            start;
    logic            adv;
    logic            emit;
    logic [EV_W-1:0] ev;
    logic            last;
    logic            set_slot;
    logic            clr_valid;
    logic            tick_inc;
  } ttt_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            hit;
    logic            at_end;
    logic            can_emit;
  } ttt_status_t;

endpackage
`default_nettype wire

FILE: hdl/ttt_ctrl.sv
`default_nettype none
module ttt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [ttt_pkg::OP_W-1:0] in_op,
  output logic                  in_stall,
  input  wire ttt_pkg::ttt_status_t st,
  output ttt_pkg::ttt_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_op != ttt_pkg::OP_IGNORED) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (st.hit) begin
          if (st.can_emit) begin
            cmd.emit = 1'b1;
            unique case (st.op)
              ttt_pkg::OP_SET: begin
                cmd.ev       = ttt_pkg::EV_SET_OK;
                cmd.last     = 1'b1;
                cmd.set_slot = 1'b1;
                state_nxt    = S_IDLE;
              end
              ttt_pkg::OP_CANCEL: begin
                cmd.ev        = ttt_pkg::EV_CANCELLED;
                cmd.last      = 1'b1;
                cmd.clr_valid = 1'b1;
                state_nxt     = S_IDLE;
              end
              default: begin
                cmd.ev        = ttt_pkg::EV_EXPIRED;
                cmd.clr_valid = 1'b1;
                if (st.at_end) begin
                  state_nxt = S_DONE;
                end else begin
                  cmd.adv = 1'b1;
                end
              end
            endcase
          end
        end else if (!st.at_end) begin
          cmd.adv = 1'b1;
        end else begin
          unique case (st.op)
            ttt_pkg::OP_SET: begin
              if (st.can_emit) begin
                cmd.emit  = 1'b1;
                cmd.ev    = ttt_pkg::EV_FULL;
                cmd.last  = 1'b1;
                state_nxt = S_IDLE;
              end
            end
            ttt_pkg::OP_CANCEL: begin
              if (st.can_emit) begin
                cmd.emit  = 1'b1;
                cmd.ev    = ttt_pkg::EV_NOT_FOUND;
                cmd.last  = 1'b1;
                state_nxt = S_IDLE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (st.can_emit) begin
          cmd.emit     = 1'b1;
          cmd.ev       = ttt_pkg::EV_TICK_DONE;
          cmd.last     = 1'b1;
          cmd.tick_inc = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/ttt_dp.sv
`default_nettype none
module ttt_dp #(
  parameter int TABLE_ENTRIES = ttt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [ttt_pkg::OP_W-1:0]     in_op,
  input  wire logic [ttt_pkg::DLY_W-1:0]    in_delay_ticks,
  input  wire logic [ttt_pkg::ID_W-1:0]     in_timer_id,
  input  wire ttt_pkg::ttt_cmd_t            cmd,
  output ttt_pkg::ttt_status_t              st,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ttt_pkg::EV_W-1:0]          out_event_res,
  output logic [ttt_pkg::ID_W-1:0]          out_result_id,
  output logic [ttt_pkg::TICK_W-1:0]        out_tick_value,
  output logic                              out_last
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [ttt_pkg::OP_W-1:0]   op_r;
  logic [ttt_pkg::DLY_W-1:0]  delay_r;
  logic [ttt_pkg::ID_W-1:0]   tid_r;
  logic [ttt_pkg::TICK_W-1:0] tick_r;
  logic [ttt_pkg::ID_W-1:0]   next_id_r;
  logic [TABLE_ENTRIES-1:0]   valid_r;
  logic [IW-1:0]              idx_r, idx_nxt;

  logic [ttt_pkg::ID_W-1:0]   id_mem [TABLE_ENTRIES];
  logic [ttt_pkg::TICK_W-1:0] dl_mem [TABLE_ENTRIES];
  logic [ttt_pkg::ID_W-1:0]   rd_id_r;
  logic [ttt_pkg::TICK_W-1:0] rd_dl_r;

  logic                       out_valid_r;
  logic [ttt_pkg::EV_W-1:0]   ev_r;
  logic [ttt_pkg::ID_W-1:0]   res_id_r, res_id_nxt;
  logic [ttt_pkg::TICK_W-1:0] tval_r;
  logic                       last_r;

  logic                       slot_valid;
  logic [ttt_pkg::TICK_W-1:0] tick_inc_val;
  logic [ttt_pkg::TICK_W-1:0] deadline;

  assign slot_valid   = valid_r[idx_r];
  assign tick_inc_val = tick_r + ttt_pkg::TICK_W'(1);
  assign deadline     = tick_r + {{(ttt_pkg::TICK_W-ttt_pkg::DLY_W){1'b0}}, delay_r};

  always_comb begin
    if (cmd.start) begin
      idx_nxt = '0;
    end else if (cmd.adv) begin
      idx_nxt = idx_r + IW'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_comb begin
    st.op       = op_r;
    st.at_end   = (idx_r == IW'(TABLE_ENTRIES - 1));
    st.can_emit = !out_valid_r || !out_stall;
    unique case (op_r)
      ttt_pkg::OP_SET:    st.hit = !slot_valid;
      ttt_pkg::OP_CANCEL: st.hit = slot_valid && (rd_id_r == tid_r);
      ttt_pkg::OP_TICK:   st.hit = slot_valid && (rd_dl_r <= tick_r);
      default:            st.hit = 1'b0;
    endcase
  end

  // slot data: synchronous read of the slot scanned next
  always_ff @(posedge clk) begin
    if (cmd.set_slot) begin
      id_mem[idx_r] <= next_id_r;
      dl_mem[idx_r] <= deadline;
    end
    rd_id_r <= id_mem[idx_nxt];
    rd_dl_r <= dl_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      next_id_r <= '0;
      valid_r   <= '0;
      idx_r     <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.set_slot) begin
        valid_r[idx_r] <= 1'b1;
        next_id_r      <= next_id_r + ttt_pkg::ID_W'(1);
      end
      if (cmd.clr_valid) begin
        valid_r[idx_r] <= 1'b0;
      end
      if (cmd.tick_inc) begin
        tick_r <= tick_inc_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= in_op;
      delay_r <= in_delay_ticks;
      tid_r   <= in_timer_id;
    end
  end

  always_comb begin
    unique case (cmd.ev) inside
      ttt_pkg::EV_SET_OK:                          res_id_nxt = next_id_r;
      ttt_pkg::EV_CANCELLED, ttt_pkg::EV_NOT_FOUND: res_id_nxt = tid_r;
      ttt_pkg::EV_EXPIRED:                         res_id_nxt = rd_id_r;
      default:                                     res_id_nxt = '0;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ev_r     <= cmd.ev;
      res_id_r <= res_id_nxt;
      tval_r   <= (op_r == ttt_pkg::OP_TICK) ? tick_inc_val : tick_r;
      last_r   <= cmd.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = ev_r;
  assign out_result_id  = res_id_r;
  assign out_tick_value = tval_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire

FILE: hdl/tick_timer_table.sv
`default_nettype none
// Table of TABLE_ENTRIES one-shot tick timers. in_op selects set (arm a timer at
// the current tick plus in_delay_ticks in the lowest free slot and report its new
// id), cancel (free the lowest slot holding in_timer_id) or tick (report every
// live timer due at the current tick in ascending slot order, then advance the
// tick and report tick done); op 3 is accepted and ignored. Items are handled one
// at a time: each one scans the slots, one slot memory read per cycle unless the
// result side stalls. out_last marks the final word of each item. No clearing
// pass is needed after reset.
module tick_timer_table #(
  parameter int TABLE_ENTRIES = ttt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ttt_pkg::OP_W-1:0]     in_op,
  input  wire logic [ttt_pkg::DLY_W-1:0]    in_delay_ticks,
  input  wire logic [ttt_pkg::ID_W-1:0]     in_timer_id,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ttt_pkg::EV_W-1:0]          out_event_res,
  output logic [ttt_pkg::ID_W-1:0]          out_result_id,
  output logic [ttt_pkg::TICK_W-1:0]        out_tick_value,
  output logic                              out_last
);

  ttt_pkg::ttt_cmd_t    cmd;
  ttt_pkg::ttt_status_t st;

  ttt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ttt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_op),
    .in_delay_ticks (in_delay_ticks),
    .in_timer_id    (in_timer_id),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_res  (out_event_res),
    .out_result_id  (out_result_id),
    .out_tick_value (out_tick_value),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

FILE: tb/tick_timer_table_checker.sv
`timescale 1ns / 1ps
module tick_timer_table_checker #(
  parameter int TABLE_ENTRIES = ttt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic [ttt_pkg::OP_W-1:0]     in_op,
  input  wire logic [ttt_pkg::DLY_W-1:0]    in_delay_ticks,
  input  wire logic [ttt_pkg::ID_W-1:0]     in_timer_id,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic [ttt_pkg::EV_W-1:0]     out_event_res,
  input  wire logic [ttt_pkg::ID_W-1:0]     out_result_id,
  input  wire logic [ttt_pkg::TICK_W-1:0]   out_tick_value,
  input  wire logic                         out_last,
  output int                                fail_count,
  output int                                words_owed
);

  typedef struct packed {
    logic [ttt_pkg::EV_W-1:0]   ev;
    logic [ttt_pkg::ID_W-1:0]   id;
    logic [ttt_pkg::TICK_W-1:0] tick;
    logic                       last;
  } timer_event_t;

  timer_event_t               event_q[$];
  logic [ttt_pkg::TICK_W-1:0] now_tick;
  logic [ttt_pkg::ID_W-1:0]   id_next;
  logic                       armed     [TABLE_ENTRIES];
  logic [ttt_pkg::ID_W-1:0]   timer_ids [TABLE_ENTRIES];
  logic [ttt_pkg::TICK_W-1:0] deadlines [TABLE_ENTRIES];
  int                         errors = 0;

  task automatic flag_mismatch(input string what, input logic [ttt_pkg::TICK_W-1:0] want,
                               input logic [ttt_pkg::TICK_W-1:0] got);
    $display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got, $realtime);
    errors++;
  endtask

  task automatic post_event(input logic [ttt_pkg::EV_W-1:0] ev,
                            input logic [ttt_pkg::ID_W-1:0] id, input logic last);
    timer_event_t w;
    w.ev   = ev;
    w.id   = id;
    w.tick = now_tick;
    w.last = last;
    event_q.push_back(w);
  endtask

  task automatic run_timer_op(input logic [ttt_pkg::OP_W-1:0] op,
                              input logic [ttt_pkg::DLY_W-1:0] dly,
                              input logic [ttt_pkg::ID_W-1:0] tid);
    logic                       done;
    logic [ttt_pkg::TICK_W-1:0] then_tick;
    logic [ttt_pkg::ID_W-1:0]   due_ids[$];
    done = 1'b0;
    if (op == ttt_pkg::OP_SET) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!done && !armed[i]) begin
          done         = 1'b1;
          armed[i]     = 1'b1;
          timer_ids[i] = id_next;
          deadlines[i] = now_tick + ttt_pkg::TICK_W'(dly);
          post_event(ttt_pkg::EV_SET_OK, id_next, 1'b1);
          id_next      = id_next + ttt_pkg::ID_W'(1);
        end
      end
      if (!done) post_event(ttt_pkg::EV_FULL, '0, 1'b1);
    end else if (op == ttt_pkg::OP_CANCEL) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!done && armed[i] && timer_ids[i] == tid) begin
          done     = 1'b1;
          armed[i] = 1'b0;
          post_event(ttt_pkg::EV_CANCELLED, tid, 1'b1);
        end
      end
      if (!done) post_event(ttt_pkg::EV_NOT_FOUND, tid, 1'b1);
    end else if (op == ttt_pkg::OP_TICK) begin
      then_tick = now_tick;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (armed[i] && deadlines[i] <= then_tick) begin
          due_ids.push_back(timer_ids[i]);
          armed[i] = 1'b0;
        end
      end
      now_tick = now_tick + ttt_pkg::TICK_W'(1);
      foreach (due_ids[k]) post_event(ttt_pkg::EV_EXPIRED, due_ids[k], 1'b0);
      post_event(ttt_pkg::EV_TICK_DONE, '0, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    timer_event_t w;
    if (!rst_n) begin
      now_tick = '0;
      id_next  = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        armed[i]     = 1'b0;
        timer_ids[i] = '0;
        deadlines[i] = '0;
      end
      event_q.delete();
    end else begin
      if (in_valid && !in_stall) run_timer_op(in_op, in_delay_ticks, in_timer_id);
      if (out_valid && !out_stall) begin
        if (event_q.size() == 0) begin
          flag_mismatch("unexpected word, event", '0, ttt_pkg::TICK_W'(out_event_res));
        end else begin
          w = event_q.pop_front();
          if (out_event_res != w.ev) flag_mismatch("event_res", ttt_pkg::TICK_W'(w.ev),
                                                   ttt_pkg::TICK_W'(out_event_res));
          if (out_result_id != w.id) flag_mismatch("result_id", ttt_pkg::TICK_W'(w.id),
                                                   ttt_pkg::TICK_W'(out_result_id));
          if (out_tick_value != w.tick) flag_mismatch("tick_value", w.tick, out_tick_value);
          if (out_last != w.last) flag_mismatch("last", ttt_pkg::TICK_W'(w.last),
                                                ttt_pkg::TICK_W'(out_last));
        end
      end
    end
    fail_count <= errors;
    words_owed <= event_q.size();
  end

endmodule

FILE: tb/tick_timer_table_tb.sv
`timescale 1ns / 1ps
module tick_timer_table_tb;

  localparam int TABLE_ENTRIES = ttt_pkg::TABLE_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 380;
  localparam int CYCLE_LIMIT  = 400000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [ttt_pkg::OP_W-1:0]   in_op = ttt_pkg::OP_TICK;
  logic [ttt_pkg::DLY_W-1:0]  in_delay_ticks = '0;
  logic [ttt_pkg::ID_W-1:0]   in_timer_id = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [ttt_pkg::EV_W-1:0]   out_event_res;
  logic [ttt_pkg::ID_W-1:0]   out_result_id;
  logic [ttt_pkg::TICK_W-1:0] out_tick_value;
  logic                       out_last;
  int                         fail_count;
  int                         words_owed;

  int                cycles = 0;
  int                burst_left = 0;
  int                sets_sent = 0;
  int                rx_cycle = 0;
  int                hold_left = 0;
  int                rx_mode = 0;
  int                rx_mode_left = 0;

  tick_timer_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_delay_ticks(in_delay_ticks), .in_timer_id(in_timer_id),
    .out_valid(out_valid), .out_stall(out_stall), .out_event_res(out_event_res),
    .out_result_id(out_result_id), .out_tick_value(out_tick_value), .out_last(out_last)
  );

  tick_timer_table_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_delay_ticks(in_delay_ticks), .in_timer_id(in_timer_id),
    .out_valid(out_valid), .out_stall(out_stall), .out_event_res(out_event_res),
    .out_result_id(out_result_id), .out_tick_value(out_tick_value), .out_last(out_last),
    .fail_count(fail_count), .words_owed(words_owed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stall modes, plus two long hold-offs to back up the block
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_cycle == 3000 || rx_cycle == 8000) begin
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ((rx_cycle % 5) < 2);
      endcase
    end
  end

  task automatic send_word(input logic [ttt_pkg::OP_W-1:0] op,
                           input logic [ttt_pkg::DLY_W-1:0] dly,
                           input logic [ttt_pkg::ID_W-1:0] tid);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) :
                                                 $urandom_range(1, 12);
    end
    burst_left--;
    if (op == ttt_pkg::OP_SET) sets_sent++;
    in_valid       <= 1'b1;
    in_op          <= op;
    in_delay_ticks <= dly;
    in_timer_id    <= tid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int                        n_real;
    int                        pick;
    logic [ttt_pkg::OP_W-1:0]  op;
    logic [ttt_pkg::DLY_W-1:0] dly;
    logic [ttt_pkg::ID_W-1:0]  tid;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty tick, zero delay, extreme fields, ignored op, fill to full
    send_word(ttt_pkg::OP_TICK, $urandom, $urandom);
    send_word(ttt_pkg::OP_SET, '0, $urandom);
    send_word(ttt_pkg::OP_TICK, $urandom, $urandom);
    send_word(ttt_pkg::OP_SET, '1, '1);
    send_word(ttt_pkg::OP_SET, 32'd1, '0);
    send_word(ttt_pkg::OP_IGNORED, $urandom, $urandom);
    send_word(ttt_pkg::OP_CANCEL, $urandom, '1);
    send_word(ttt_pkg::OP_CANCEL, '0, 32'd1);
    send_word(ttt_pkg::OP_CANCEL, '1, 32'd1);
    repeat (TABLE_ENTRIES) send_word(ttt_pkg::OP_SET, '0, $urandom);
    send_word(ttt_pkg::OP_TICK, $urandom, $urandom);

    n_real = 0;
    while (n_real < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = ttt_pkg::OP_SET;
      else if (pick < 60) op = ttt_pkg::OP_CANCEL;
      else if (pick < 95) op = ttt_pkg::OP_TICK;
      else                op = ttt_pkg::OP_IGNORED;
      pick = $urandom_range(0, 99);
      if (op != ttt_pkg::OP_SET) dly = $urandom;
      else if (pick < 60)        dly = $urandom_range(0, 8);
      else if (pick < 95)        dly = $urandom_range(0, 40);
      else                       dly = $urandom;
      pick = $urandom_range(0, 99);
      if (op != ttt_pkg::OP_CANCEL || sets_sent == 0) tid = $urandom;
      else if (pick < 70) tid = $urandom_range(sets_sent - 1,
                                               (sets_sent > 16) ? sets_sent - 16 : 0);
      else if (pick < 85) tid = $urandom_range(0, sets_sent);
      else                tid = $urandom;
      send_word(op, dly, tid);
      if (op != ttt_pkg::OP_IGNORED) n_real++;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (2 * TABLE_ENTRIES + 8) @(posedge clk);
    if (fail_count == 0 && words_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
